/* src/ffba_pkg.sv */
// Shared constants, codes and helper functions for the free block bitmap allocator.
package ffba_pkg;

    // Map geometry (WORD_BITS must be a power of two)
    localparam int MAP_BLOCKS = 512;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 9;
    localparam int STATUS_W = 2;

    // Width wide enough to compare a block index against the map size
    localparam int CMP_W = 16;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_TAKE_FIRST = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAKE       = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FORMAT     = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef logic [WORD_BITS-1:0] map_word_t;

    // Bits of map word w that stand for real blocks
    function automatic map_word_t word_valid_mask(input logic [WADDR_W-1:0] w);
        map_word_t m;
        int        base;
        m    = '0;
        base = int'(w) * WORD_BITS;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            m[i] = ((base + i) < MAP_BLOCKS);
        end
        return m;
    endfunction

    // Position of the lowest set bit (zero when the word is zero)
    function automatic logic [BIT_W-1:0] lowest_set(input map_word_t v);
        map_word_t         lone;
        logic [BIT_W-1:0]  pos;
        lone = v & (~v + map_word_t'(1));
        pos  = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (lone[i])
            begin
                pos = pos | BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* src/ffba_map_ram.sv */
// Generic simple dual-port synchronous RAM with registered read data.
module ffba_map_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/free_block_bitmap_allocator.sv */
// Top level of the free block bitmap allocator: request sequencer around the map RAM.
//
// A request is taken when start is high and busy is low; its one result beat shows on
// result_index and status for exactly one cycle while done is high, and cannot be held
// off. Format and out-of-range take/release requests never raise busy and strobe done
// in the cycle after acceptance. Take and release read the map word, then write it back
// in the write-back state while busy, done in the cycle after. Take-first scans the map
// one word per cycle through the single RAM read port, busy until it has checked the
// word with the first free block, or the last of the 16 words if full; done follows.
// A new request may be given in the cycle that done is high. Reset and format mark every
// block free at once by clearing per-word valid flags; there is no clearing pass.
module free_block_bitmap_allocator
    import ffba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [INDEX_W-1:0]  block_index,
    output logic                done,
    output logic [INDEX_W-1:0]  result_index,
    output logic [STATUS_W-1:0] status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [WADDR_W-1:0]   addr_reg, addr_next;
    logic [MAP_WORDS-1:0] valid_reg, valid_next;
    logic                 done_reg, done_next;
    logic [INDEX_W-1:0]   res_idx_reg, res_idx_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 ram_we, ram_re;
    logic [WADDR_W-1:0]   ram_waddr, ram_raddr;
    map_word_t            ram_wdata, ram_rdata;

    logic                 accept;
    logic                 in_range;
    logic [WADDR_W-1:0]   in_word;
    map_word_t            cur_word, scan_bits, bit_sel;
    logic [BIT_W-1:0]     low_pos;

    ffba_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WADDR_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept   = start && !busy;
    assign in_range = (CMP_W'(block_index) < CMP_W'(MAP_BLOCKS));
    assign in_word  = WADDR_W'(block_index >> BIT_W);

    // word just read; a word never written since format reads as all free
    assign cur_word  = valid_reg[addr_reg] ? ram_rdata : word_valid_mask(addr_reg);
    assign scan_bits = cur_word & word_valid_mask(addr_reg);
    assign low_pos   = lowest_set(scan_bits);
    assign bit_sel   = map_word_t'(1) << idx_reg[BIT_W-1:0];

    // request sequencer
    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        idx_next     = idx_reg;
        addr_next    = addr_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        res_idx_next = res_idx_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = cur_word;
        ram_re       = 1'b0;
        ram_raddr    = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    idx_next  = block_index;
                    case (func)
                        FUNC_TAKE_FIRST:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            addr_next  = '0;
                            state_next = S_SCAN;
                        end
                        FUNC_TAKE, FUNC_RELEASE:
                        begin
                            if (in_range)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = in_word;
                                addr_next  = in_word;
                                state_next = S_MOD;
                            end
                            else
                            begin
                                done_next    = 1'b1;
                                res_idx_next = block_index;
                                status_next  = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            // format: every word reads as all free again
                            valid_next   = '0;
                            done_next    = 1'b1;
                            res_idx_next = '0;
                            status_next  = ST_OK;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                if (func_reg == FUNC_TAKE)
                begin
                    ram_wdata = cur_word & ~bit_sel;
                end
                else
                begin
                    ram_wdata = cur_word | bit_sel;
                end
                valid_next[addr_reg] = 1'b1;
                done_next    = 1'b1;
                res_idx_next = idx_reg;
                status_next  = ST_OK;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_bits != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_reg;
                    ram_wdata = cur_word & ~(map_word_t'(1) << low_pos);
                    valid_next[addr_reg] = 1'b1;
                    done_next    = 1'b1;
                    res_idx_next = INDEX_W'({addr_reg, low_pos});
                    status_next  = ST_OK;
                    state_next   = S_IDLE;
                end
                else if (addr_reg == WADDR_W'(MAP_WORDS - 1))
                begin
                    done_next    = 1'b1;
                    res_idx_next = '0;
                    status_next  = ST_FULL;
                    state_next   = S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_reg + WADDR_W'(1);
                    addr_next = addr_reg + WADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        idx_reg     <= idx_next;
        addr_reg    <= addr_next;
        res_idx_reg <= res_idx_next;
        status_reg  <= status_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_index = res_idx_reg;
    assign status       = status_reg;

    // a result beat only leaves once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // map writes happen only in the write-back cycles
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_MOD || state_reg == S_SCAN))
        else $error("map write outside write-back");

    // format answers in the next cycle with ok
    a_format: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_FORMAT) |=> (done && status == ST_OK && valid_reg == '0))
        else $error("format result wrong");

    // scan address stays inside the map
    a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (addr_reg <= WADDR_W'(MAP_WORDS - 1)))
        else $error("scan address out of map");

    // a read-modify-write returns to idle with done in the cycle after S_MOD
    a_mod_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |=> (state_reg == S_IDLE && done))
        else $error("write-back did not finish");

endmodule
